// ===== rtl/mouse_motion_smoother_defines.svh =====
// Assertion macros for the mouse motion smoother.
`ifndef MOUSE_MOTION_SMOOTHER_DEFINES_SVH
`define MOUSE_MOTION_SMOOTHER_DEFINES_SVH

// Same-cycle implication.
`define MMS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mouse_motion_smoother: same-cycle check failed");

// Next-cycle implication.
`define MMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mouse_motion_smoother: next-cycle check failed");

`endif

// ===== rtl/mms_pkg.sv =====
`timescale 1ns / 1ps
package mms_pkg;

   // Field widths
   localparam int ACC_W   = 24;
   localparam int TOT_W   = 32;
   localparam int ZT_W    = 24;
   localparam int DT_W    = 20;
   localparam int GAIN_W  = 16;
   localparam int MOVE_W  = 16;
   localparam int VAL_W   = 32;
   localparam int V_W     = 40;   // accumulator magnitude in Q24.16
   localparam int MAG_W   = 41;   // magnitude after rescale
   localparam int SPS_W   = 48;   // microseconds per sample, Q16
   localparam int REQ_TDATA_W = 72;

   // Shared unit sizes
   localparam int ALU_NW = 76;    // dividend / product width
   localparam int ALU_DW = 49;    // divisor width
   localparam int ALU_MW = 20;    // multiplier bits
   localparam int ALU_CW = 7;     // step counter

   localparam logic [TOT_W-1:0] TT_RESET = 32'd8000;
   localparam logic [DT_W-1:0]  MAXFT_RESET = 20'd250000;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd6554;

   // Request kinds
   localparam logic [1:0] REQ_FRAME_START = 2'd0;
   localparam logic [1:0] REQ_MOTION      = 2'd1;
   localparam logic [1:0] REQ_FRAME_END   = 2'd2;

   // Axis codes
   localparam logic [1:0] AXIS_X     = 2'd0;
   localparam logic [1:0] AXIS_Y     = 2'd1;
   localparam logic [1:0] AXIS_WHEEL = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_SMOOTH_EN = 2'd0;
   localparam logic [1:0] CSR_MAX_FT    = 2'd1;
   localparam logic [1:0] CSR_GAIN      = 2'd2;

   typedef enum logic {ALU_MUL, ALU_DIV} alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_stat_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AXIS, ST_SPS, ST_BRANCH, ST_MUL_SM, ST_DIV_SM,
      ST_MUL_V, ST_DIV_V, ST_DIV_CNT, ST_DIV_Q, ST_GAIN, ST_EMIT
   } seq_state_type;

   // Signed 32-bit saturation of a sign and magnitude
   function automatic logic [VAL_W-1:0] sat_q32(input logic neg,
                                                 input logic [MAG_W-1:0] mag);
      logic [VAL_W-1:0] r;
      if (!neg)
         r = (mag > MAG_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : mag[VAL_W-1:0];
      else
         r = (mag > MAG_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                 : (32'd0 - mag[VAL_W-1:0]);
      return r;
   endfunction

endpackage

// ===== rtl/mms_alu.sv =====
`timescale 1ns / 1ps
// Shared iterative unit: shift-add multiply, restoring divide, one bit a cycle.
module mms_alu (
   input  logic                       clock,
   input  logic                       reset,
   input  mms_pkg::alu_cmd_type       cmd,
   input  logic [mms_pkg::ALU_NW-1:0] opa,
   input  logic [mms_pkg::ALU_DW-1:0] opb,
   output mms_pkg::alu_stat_type      stat,
   output logic [mms_pkg::ALU_NW-1:0] result
);
   import mms_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   alu_op_type        op_ff, op_in;
   logic [ALU_CW-1:0] cnt_ff, cnt_in;
   logic [ALU_NW-1:0] acc_ff, acc_in;
   logic [ALU_DW-1:0] rem_ff, rem_in;
   logic [ALU_NW-1:0] opnd_ff, opnd_in;
   logic [ALU_MW-1:0] mlt_ff, mlt_in;

   logic [ALU_DW:0]   rem_sh;
   logic [ALU_DW+1:0] diff;
   logic              ge;

   // One step of the selected operation
   always_comb begin
      rem_sh  = {rem_ff, acc_ff[ALU_NW-1]};
      diff    = {1'b0, rem_sh} - {2'b00, opnd_ff[ALU_DW-1:0]};
      ge      = ~diff[ALU_DW+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      opnd_in = opnd_ff;
      mlt_in  = mlt_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         rem_in  = '0;
         mlt_in  = opb[ALU_MW-1:0];
         if (cmd.op == ALU_DIV) begin
            acc_in  = opa;
            opnd_in = ALU_NW'(opb);
            cnt_in  = ALU_CW'(ALU_NW - 1);
         end else begin
            acc_in  = '0;
            opnd_in = opa;
            cnt_in  = ALU_CW'(ALU_MW - 1);
         end
      end else if (busy_ff) begin
         case (op_ff)
            ALU_DIV: begin
               acc_in = {acc_ff[ALU_NW-2:0], ge};
               rem_in = ge ? diff[ALU_DW-1:0] : rem_sh[ALU_DW-1:0];
            end
            default: begin
               acc_in = {acc_ff[ALU_NW-2:0], 1'b0} + (mlt_ff[ALU_MW-1] ? opnd_ff : '0);
               mlt_in = {mlt_ff[ALU_MW-2:0], 1'b0};
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      opnd_ff <= opnd_in;
      mlt_ff  <= mlt_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = acc_ff;

endmodule

// ===== rtl/mouse_motion_smoother.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Ports                  Contents
// req       in   req_tvalid/tready      tdata: move_x, move_y, move_wheel, frame_time_us
//                                       tuser: req_type
// rsp       out  rsp_tvalid/tready      tdata: rel_value; tuser: axis_id; tlast: last
// csr       in   csr_we/addr/wdata      smoothing_enable, max_frame_time_us, output_gain_q16
//
// Frame start and motion items are handled on accept; every request needs the
// output register free. A frame end, once accepted, runs two axes through one
// shared multiply/divide unit: an unsmoothed axis needs only the gain multiply,
// a smoothed one up to the rate, count and quotient divides plus the gain
// multiply.
// Reset is synchronous; the input is not ready until a frame end is finished,
// and a stalled output holds the sequencer in its emit step.
`include "mouse_motion_smoother_defines.svh"
module mouse_motion_smoother (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [15:0] move_x, [31:16] move_y, [47:32] move_wheel, [67:48] frame_time_us
   input  logic [mms_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [31:0] rel_value
   output logic [mms_pkg::VAL_W-1:0]       rsp_tdata,
   // [1:0] axis_id
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_addr,
   input  logic [mms_pkg::DT_W-1:0]        csr_wdata
);
   import mms_pkg::*;

   // Sequencer and configuration
   seq_state_type state_ff, state_in;
   logic ax_ff, ax_in;
   logic go_ff, go_in;
   logic en_ff, en_in;
   logic [DT_W-1:0] maxft_ff, maxft_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;

   // Axis state
   logic signed [ACC_W-1:0] accum_ff [2];
   logic signed [ACC_W-1:0] accum_in [2];
   logic [TOT_W-1:0] stot_ff [2];
   logic [TOT_W-1:0] stot_in [2];
   logic [TOT_W-1:0] tt_ff [2];
   logic [TOT_W-1:0] tt_in [2];
   logic signed [VAL_W-1:0] sm_ff [2];
   logic signed [VAL_W-1:0] sm_in [2];
   logic [ZT_W-1:0] zt_ff [2];
   logic [ZT_W-1:0] zt_in [2];
   logic [DT_W-1:0] cft_ff, cft_in;
   logic sampled_ff, sampled_in;

   // Work registers
   logic [SPS_W-1:0] sps_ff, sps_in;
   logic [MAG_W-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;

   // Output register
   logic rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_data_ff, rsp_data_in;
   logic [1:0] rsp_axis_ff, rsp_axis_in;
   logic rsp_last_ff, rsp_last_in;

   // Shared unit
   alu_cmd_type alu_cmd;
   alu_stat_type alu_stat;
   logic [ALU_NW-1:0] alu_opa, alu_res;
   logic [ALU_DW-1:0] alu_opb;

   // Decoded input and current axis values
   logic [1:0] req_kind;
   logic signed [MOVE_W-1:0] mv [2];
   logic signed [MOVE_W-1:0] mv_wheel;
   logic [DT_W-1:0] req_ft;
   logic req_acc, out_free, op_state;
   logic signed [ACC_W-1:0] acc_cur;
   logic [ACC_W-1:0] acc_abs;
   logic [V_W-1:0] vmag;
   logic v_neg, v_zero;
   logic signed [VAL_W-1:0] sm_cur;
   logic [VAL_W-1:0] sm_mag;
   logic [TOT_W-1:0] s_cur;
   logic [ZT_W:0] zt_sum;
   logic [ZT_W-1:0] zt_new;
   logic [SPS_W-1:0] sps_res;
   logic [ALU_DW-1:0] cnt_res;
   logic zt_cond, dt_cond;

   assign req_kind = req_tuser;
   assign mv[0]    = req_tdata[15:0];
   assign mv[1]    = req_tdata[31:16];
   assign mv_wheel = req_tdata[47:32];
   assign req_ft   = req_tdata[67:48];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_acc    = req_tvalid && req_tready;

   // Current axis operands
   always_comb begin
      acc_cur = accum_ff[ax_ff];
      v_neg   = acc_cur[ACC_W-1];
      v_zero  = (acc_cur == '0);
      acc_abs = v_neg ? (ACC_W'(0) - acc_cur) : acc_cur;
      vmag    = {acc_abs, 16'd0};
      sm_cur  = sm_ff[ax_ff];
      sm_mag  = sm_cur[VAL_W-1] ? (VAL_W'(0) - sm_cur) : sm_cur;
      s_cur   = (stot_ff[ax_ff] == '0) ? TOT_W'(1) : stot_ff[ax_ff];
      zt_sum  = {1'b0, zt_ff[ax_ff]} + (ZT_W+1)'(cft_ff);
      zt_new  = zt_sum[ZT_W] ? '1 : zt_sum[ZT_W-1:0];
      sps_res = (alu_res[SPS_W-1:0] == '0) ? SPS_W'(1) : alu_res[SPS_W-1:0];
      cnt_res = (alu_res[ALU_DW-1:0] == '0) ? ALU_DW'(1) : alu_res[ALU_DW-1:0];
      zt_cond = (SPS_W'({zt_new, 16'd0}) < sps_ff);
      dt_cond = (ALU_DW'({cft_ff, 16'd0}) < {sps_ff, 1'b0});
   end

   assign op_state = (state_ff == ST_SPS) || (state_ff == ST_MUL_SM) ||
                     (state_ff == ST_DIV_SM) || (state_ff == ST_MUL_V) ||
                     (state_ff == ST_DIV_V) || (state_ff == ST_DIV_CNT) ||
                     (state_ff == ST_DIV_Q) || (state_ff == ST_GAIN);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_acc && req_kind == REQ_FRAME_END) state_in = ST_AXIS;
         ST_AXIS:
            if (!en_ff || cft_ff >= maxft_ff) state_in = ST_GAIN;
            else state_in = ST_SPS;
         ST_SPS:
            if (alu_stat.done) state_in = ST_BRANCH;
         ST_BRANCH:
            if (v_zero) state_in = zt_cond ? ST_MUL_SM : ST_GAIN;
            else if (sm_cur == '0) state_in = ST_GAIN;
            else state_in = dt_cond ? ST_MUL_V : ST_DIV_CNT;
         ST_MUL_SM:
            if (alu_stat.done) state_in = ST_DIV_SM;
         ST_DIV_SM:
            if (alu_stat.done) state_in = ST_GAIN;
         ST_MUL_V:
            if (alu_stat.done) state_in = ST_DIV_V;
         ST_DIV_V:
            if (alu_stat.done) state_in = ST_GAIN;
         ST_DIV_CNT:
            if (alu_stat.done) state_in = ST_DIV_Q;
         ST_DIV_Q:
            if (alu_stat.done) state_in = ST_GAIN;
         ST_GAIN:
            if (alu_stat.done) state_in = ST_EMIT;
         ST_EMIT:
            if (out_free) state_in = ax_ff ? ST_IDLE : ST_AXIS;
         default:
            state_in = ST_IDLE;
      endcase
   end

   // Shared unit command and operands
   always_comb begin
      alu_cmd.start = op_state && !go_ff;
      alu_cmd.op    = ALU_DIV;
      alu_opa       = '0;
      alu_opb       = '0;
      go_in         = op_state && !alu_stat.done;
      case (state_ff)
         ST_SPS: begin
            alu_opa = ALU_NW'({tt_ff[ax_ff], 16'd0});
            alu_opb = ALU_DW'(s_cur);
         end
         ST_MUL_SM: begin
            alu_cmd.op = ALU_MUL;
            alu_opa    = ALU_NW'(sm_mag);
            alu_opb    = ALU_DW'(cft_ff);
         end
         ST_DIV_SM, ST_DIV_V: begin
            alu_opa = {alu_res[ALU_NW-17:0], 16'd0};
            alu_opb = ALU_DW'(sps_ff);
         end
         ST_MUL_V: begin
            alu_cmd.op = ALU_MUL;
            alu_opa    = ALU_NW'(vmag);
            alu_opb    = ALU_DW'(cft_ff);
         end
         ST_DIV_CNT: begin
            alu_opa = ALU_NW'({cft_ff, 17'd0}) + ALU_NW'(sps_ff);
            alu_opb = {sps_ff, 1'b0};
         end
         ST_DIV_Q: begin
            alu_opa = ALU_NW'(vmag);
            alu_opb = cnt_res;
         end
         ST_GAIN: begin
            alu_cmd.op = ALU_MUL;
            alu_opa    = ALU_NW'(mag_ff);
            alu_opb    = ALU_DW'(gain_ff);
         end
         default: begin
            alu_cmd.op = ALU_DIV;
         end
      endcase
   end

   mms_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opa    (alu_opa),
      .opb    (alu_opb),
      .stat   (alu_stat),
      .result (alu_res)
   );

   // Datapath updates
   always_comb begin
      logic signed [ACC_W:0] acc_sum;
      logic [MOVE_W-1:0] mv_abs;
      logic [TOT_W:0] tot_sum;
      logic [TOT_W:0] tt_sum;

      acc_sum    = '0;
      mv_abs     = '0;
      tot_sum    = '0;
      tt_sum     = '0;
      en_in      = en_ff;
      maxft_in   = maxft_ff;
      gain_in    = gain_ff;
      ax_in      = ax_ff;
      cft_in     = cft_ff;
      sampled_in = sampled_ff;
      sps_in     = sps_ff;
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      accum_in   = accum_ff;
      stot_in    = stot_ff;
      tt_in      = tt_ff;
      sm_in      = sm_ff;
      zt_in      = zt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_axis_in  = rsp_axis_ff;
      rsp_last_in  = rsp_last_ff;

      // configuration writes
      if (csr_we) begin
         case (csr_addr)
            CSR_SMOOTH_EN: en_in    = csr_wdata[0];
            CSR_MAX_FT:    maxft_in = csr_wdata;
            CSR_GAIN:      gain_in  = csr_wdata[GAIN_W-1:0];
            default:       ;
         endcase
      end

      case (state_ff)
         ST_IDLE:
            if (req_acc) begin
               case (req_kind)
                  REQ_FRAME_START: begin
                     cft_in     = req_ft;
                     sampled_in = 1'b0;
                  end
                  REQ_MOTION: begin
                     for (int i = 0; i < 2; i++) begin
                        acc_sum = (ACC_W+1)'(accum_ff[i]) + (ACC_W+1)'(mv[i]);
                        if (acc_sum[ACC_W] != acc_sum[ACC_W-1])
                           accum_in[i] = acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                        : {1'b0, {(ACC_W-1){1'b1}}};
                        else
                           accum_in[i] = acc_sum[ACC_W-1:0];
                        mv_abs = mv[i][MOVE_W-1] ? (MOVE_W'(0) - mv[i]) : mv[i];
                        tot_sum = {1'b0, stot_ff[i]} + (TOT_W+1)'(mv_abs);
                        stot_in[i] = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
                        tt_sum = {1'b0, tt_ff[i]} + (TOT_W+1)'(cft_ff);
                        if (!sampled_ff && mv[i] != '0 && sm_ff[i] != '0)
                           tt_in[i] = tt_sum[TOT_W] ? '1 : tt_sum[TOT_W-1:0];
                     end
                     sampled_in   = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = {mv_wheel, 16'd0};
                     rsp_axis_in  = AXIS_WHEEL;
                     rsp_last_in  = 1'b1;
                  end
                  REQ_FRAME_END:
                     ax_in = 1'b0;
                  default: ;
               endcase
            end
         ST_AXIS: begin
            mag_in = MAG_W'(vmag);
            neg_in = v_neg;
            if (en_ff && cft_ff >= maxft_ff) begin
               sm_in[ax_ff] = '0;
               zt_in[ax_ff] = '0;
            end
         end
         ST_SPS:
            if (alu_stat.done) sps_in = sps_res;
         ST_BRANCH:
            if (v_zero) begin
               zt_in[ax_ff] = zt_new;
               if (!zt_cond) begin
                  sm_in[ax_ff] = '0;
                  mag_in       = '0;
                  neg_in       = 1'b0;
               end
            end else begin
               zt_in[ax_ff] = '0;
               if (sm_cur == '0) sm_in[ax_ff] = sat_q32(v_neg, MAG_W'(vmag));
            end
         ST_DIV_SM:
            if (alu_stat.done) begin
               mag_in = alu_res[MAG_W-1:0];
               neg_in = sm_cur[VAL_W-1];
            end
         ST_DIV_V:
            if (alu_stat.done) begin
               mag_in       = alu_res[MAG_W-1:0];
               sm_in[ax_ff] = sat_q32(v_neg, alu_res[MAG_W-1:0]);
            end
         ST_DIV_Q:
            if (alu_stat.done) sm_in[ax_ff] = sat_q32(v_neg, alu_res[MAG_W-1:0]);
         ST_EMIT:
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_data_in     = sat_q32(!neg_ff, alu_res[MAG_W+15:16]);
               rsp_axis_in     = ax_ff ? AXIS_Y : AXIS_X;
               rsp_last_in     = ax_ff;
               accum_in[ax_ff] = '0;
               ax_in           = !ax_ff;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ax_ff        <= 1'b0;
         go_ff        <= 1'b0;
         en_ff        <= 1'b0;
         maxft_ff     <= MAXFT_RESET;
         gain_ff      <= GAIN_RESET;
         cft_ff       <= '0;
         sampled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 2; i++) begin
            accum_ff[i] <= '0;
            stot_ff[i]  <= TOT_W'(1);
            tt_ff[i]    <= TT_RESET;
            sm_ff[i]    <= '0;
            zt_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ax_ff        <= ax_in;
         go_ff        <= go_in;
         en_ff        <= en_in;
         maxft_ff     <= maxft_in;
         gain_ff      <= gain_in;
         cft_ff       <= cft_in;
         sampled_ff   <= sampled_in;
         rsp_valid_ff <= rsp_valid_in;
         accum_ff     <= accum_in;
         stot_ff      <= stot_in;
         tt_ff        <= tt_in;
         sm_ff        <= sm_in;
         zt_ff        <= zt_in;
      end
      sps_ff      <= sps_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
      rsp_axis_ff <= rsp_axis_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_axis_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks
   `MMS_ASSERT_SAME(a_x_not_last, clock, reset, rsp_tvalid && rsp_tuser == AXIS_X, !rsp_tlast)
   `MMS_ASSERT_SAME(a_alu_owned, clock, reset, alu_stat.busy || alu_stat.done, go_ff)
   `MMS_ASSERT_NEXT(a_end_starts, clock, reset, req_acc && req_kind == REQ_FRAME_END, state_ff == ST_AXIS)

endmodule
